/* rtl/cms_pkg.sv */
`default_nettype none

package cms_pkg;

    localparam int TABLE_SIZE  = 16384;
    localparam int COUNT_WIDTH = 32;
    localparam int IDX_W       = $clog2(TABLE_SIZE);
    localparam int HASH_W      = 64;
    localparam int BYTE_W      = 8;
    localparam int EST_W       = 32;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    localparam logic [HASH_W-1:0] DJB_START = HASH_W'(5381);

    localparam logic CMD_INC   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef logic [IDX_W-1:0]       idx_t;
    typedef logic [HASH_W-1:0]      hash_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;

    // one finished key on its way from the front to the back
    typedef struct packed {
        logic  cmd;
        hash_t jen;
        idx_t  idx_b;
        idx_t  idx_c;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

`default_nettype wire

/* rtl/cms_front.sv */
`default_nettype none

module cms_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [cms_pkg::BYTE_W-1:0]   s_tdata,
    input  wire logic                         s_tuser,
    input  wire logic                         s_tlast,
    input  wire logic                         clear_done,
    input  wire cms_pkg::fifo_stat_t          q_stat,
    output logic                              q_push,
    output cms_pkg::op_t                      q_op
);
    import cms_pkg::*;

    hash_t jen_reg, jen_next;
    hash_t prime_reg, prime_next;
    hash_t djb_reg, djb_next;
    hash_t jen_add, jen_mix, jen_upd, prime_upd, djb_upd, b_ext;
    logic  accept;

    assign s_tready = clear_done && !q_stat.full;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        b_ext     = HASH_W'(s_tdata);
        jen_add   = jen_reg + b_ext;
        jen_mix   = jen_add + (jen_add << 10);
        jen_upd   = jen_mix ^ (jen_mix >> 6);
        prime_upd = (prime_reg << 10) - (prime_reg << 4) + prime_reg + b_ext;
        djb_upd   = (djb_reg << 5) + djb_reg + b_ext;

        jen_next   = jen_reg;
        prime_next = prime_reg;
        djb_next   = djb_reg;
        if (accept)
        begin
            if (s_tlast)
            begin
                jen_next   = '0;
                prime_next = '0;
                djb_next   = DJB_START;
            end
            else
            begin
                jen_next   = jen_upd;
                prime_next = prime_upd;
                djb_next   = djb_upd;
            end
        end

        q_push    = accept && s_tlast;
        q_op.cmd  = s_tuser;
        q_op.jen  = jen_upd;
        q_op.idx_b = prime_upd[IDX_W-1:0];
        q_op.idx_c = djb_upd[IDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jen_reg   <= '0;
            prime_reg <= '0;
            djb_reg   <= DJB_START;
        end
        else
        begin
            jen_reg   <= jen_next;
            prime_reg <= prime_next;
            djb_reg   <= djb_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/cms_fifo.sv */
`default_nettype none

module cms_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire cms_pkg::op_t       push_op,
    input  wire logic               pop,
    output cms_pkg::op_t            pop_op,
    output cms_pkg::fifo_stat_t     stat
);
    import cms_pkg::*;

    op_t                  slot_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     cnt_reg, cnt_next;
    logic                 do_push, do_pop;

    always_comb
    begin
        stat.full   = (cnt_reg == (FIFO_AW+1)'(FIFO_DEPTH));
        stat.empty  = (cnt_reg == '0);
        do_push     = push && !stat.full;
        do_pop      = pop && !stat.empty;
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
        pop_op = slot_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/cms_back.sv */
`default_nettype none

module cms_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire cms_pkg::fifo_stat_t         q_stat,
    input  wire cms_pkg::op_t                q_op,
    output logic                             q_pop,
    output logic                             clear_done,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [cms_pkg::EST_W-1:0]        m_tdata
);
    import cms_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_UPDATE
    } state_t;

    count_t mem_a [TABLE_SIZE];
    count_t mem_b [TABLE_SIZE];
    count_t mem_c [TABLE_SIZE];

    state_t             state_reg, state_next;
    idx_t               clr_idx_reg, clr_idx_next;
    logic               cmd_reg, cmd_next;
    hash_t              fin_reg, fin_next;
    idx_t               idx_a_reg, idx_a_next;
    idx_t               idx_b_reg, idx_b_next;
    idx_t               idx_c_reg, idx_c_next;
    logic               valid_reg, valid_next;
    logic [EST_W-1:0]   est_reg, est_next;

    count_t             rd_a, rd_b, rd_c;
    idx_t               rd_addr_a;
    idx_t               wr_a, wr_b, wr_c;
    count_t             wd_a, wd_b, wd_c;
    logic               wr_en;
    hash_t              h1, h2, h3;
    count_t             min_ab, min_abc;
    logic               out_free;

    function automatic count_t sat_inc(input count_t v);
        count_t r;
        r = (v == '1) ? v : v + 1'b1;
        return r;
    endfunction

    assign clear_done = (state_reg != ST_CLEAR);
    assign m_tvalid   = valid_reg;
    assign m_tdata    = est_reg;

    always_comb
    begin
        h1      = q_op.jen + (q_op.jen << 3);
        h2      = h1 ^ (h1 >> 11);
        h3      = fin_reg + (fin_reg << 15);
        min_ab  = (rd_b < rd_a) ? rd_b : rd_a;
        min_abc = (rd_c < min_ab) ? rd_c : min_ab;
        out_free = !valid_reg || m_tready;

        rd_addr_a = (state_reg == ST_HASH) ? h3[IDX_W-1:0] : idx_a_reg;

        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        cmd_next     = cmd_reg;
        fin_next     = fin_reg;
        idx_a_next   = idx_a_reg;
        idx_b_next   = idx_b_reg;
        idx_c_next   = idx_c_reg;
        valid_next   = valid_reg && !m_tready;
        est_next     = est_reg;
        q_pop        = 1'b0;
        wr_en        = 1'b0;
        wr_a         = idx_a_reg;
        wr_b         = idx_b_reg;
        wr_c         = idx_c_reg;
        wd_a         = sat_inc(rd_a);
        wd_b         = sat_inc(rd_b);
        wd_c         = sat_inc(rd_c);

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_a         = clr_idx_reg;
                wr_b         = clr_idx_reg;
                wr_c         = clr_idx_reg;
                wd_a         = '0;
                wd_b         = '0;
                wd_c         = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == IDX_W'(TABLE_SIZE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_op.cmd;
                    fin_next   = h2;
                    idx_b_next = q_op.idx_b;
                    idx_c_next = q_op.idx_c;
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                idx_a_next = h3[IDX_W-1:0];
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (cmd_reg == CMD_INC)
                begin
                    wr_en      = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    valid_next = 1'b1;
                    if (64'(min_abc) > 64'(32'hFFFF_FFFF))
                    begin
                        est_next = '1;
                    end
                    else
                    begin
                        est_next = EST_W'(min_abc);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_a[wr_a] <= wd_a;
        end
        rd_a <= mem_a[rd_addr_a];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_b[wr_b] <= wd_b;
        end
        rd_b <= mem_b[idx_b_reg];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_c[wr_c] <= wd_c;
        end
        rd_c <= mem_c[idx_c_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
            cmd_reg     <= CMD_INC;
            fin_reg     <= '0;
            idx_a_reg   <= '0;
            idx_b_reg   <= '0;
            idx_c_reg   <= '0;
            valid_reg   <= 1'b0;
            est_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            cmd_reg     <= cmd_next;
            fin_reg     <= fin_next;
            idx_a_reg   <= idx_a_next;
            idx_b_reg   <= idx_b_next;
            idx_c_reg   <= idx_c_next;
            valid_reg   <= valid_next;
            est_reg     <= est_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/count_min_sketch_three_hash_core.sv */
// A query's estimate shows on m_tdata from an output register after the back end's update step.
// Throughput: one key byte per cycle into the hash front while the 4-entry queue has room.
// The counter back end takes one key at a time through hash finish, table read and update.
// Reset: asynchronous, active low; afterwards the three tables are zeroed
// one entry per cycle over all 16384 entries, with s_tready held low.
`default_nettype none

module count_min_sketch_three_hash_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [cms_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] key_byte
    input  wire logic                        s_tuser,   // [0] cmd
    input  wire logic                        s_tlast,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [cms_pkg::EST_W-1:0]        m_tdata    // [31:0] estimate
);
    import cms_pkg::*;

    fifo_stat_t q_stat;
    op_t        push_op, pop_op;
    logic       q_push, q_pop, clear_done;

    cms_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .clear_done (clear_done),
        .q_stat     (q_stat),
        .q_push     (q_push),
        .q_op       (push_op)
    );

    cms_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (push_op),
        .pop     (q_pop),
        .pop_op  (pop_op),
        .stat    (q_stat)
    );

    cms_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_stat     (q_stat),
        .q_op       (pop_op),
        .q_pop      (q_pop),
        .clear_done (clear_done),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire

/* rtl/cms_checker.sv */
`default_nettype none

module cms_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic s_tready,
    input wire logic m_tvalid,
    input wire logic m_tready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped while stalled");

    a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !s_tready && !m_tvalid)
        else $error("block active before table clear");

    a_key_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !($past(m_tvalid, 2) && !$past(m_tvalid, 3)))
        else $error("results closer than one key per three cycles");

endmodule

bind count_min_sketch_three_hash_core cms_checker u_cms_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
